### sv/bdc_pkg.sv
package bdc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LEVEL     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RISE_STEP        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FALL_STEP        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOW_DIVISOR     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BOUNCE_TICKS     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS       = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_HIGH_PERCENT = 3'd6;

	localparam logic [15:0] RST_TARGET_LEVEL     = 16'hffff;
	localparam logic [7:0]  RST_RISE_STEP        = 8'd15;
	localparam logic [7:0]  RST_FALL_STEP        = 8'd50;
	localparam logic [7:0]  RST_SLOW_DIVISOR     = 8'd3;
	localparam logic [15:0] RST_BOUNCE_TICKS     = 16'd100;
	localparam logic [15:0] RST_HOLD_TICKS       = 16'd500;
	localparam logic [6:0]  RST_MIN_HIGH_PERCENT = 7'd80;

	localparam logic [15:0] LEVEL_MAX     = 16'hffff;
	localparam logic [15:0] COUNT_MAX     = 16'hffff;
	localparam logic [6:0]  PERCENT_SCALE = 7'd100;

	localparam logic [1:0] FLAGS_HIGH = 2'b01;
	localparam logic [1:0] FLAGS_ONCE = 2'b10;

	localparam int DIV_BITS_PER_CYCLE = 2;
	localparam int DIV_CYCLES         = 8 / DIV_BITS_PER_CYCLE;
	localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

	typedef enum logic [1:0] {
		EV_NONE,
		EV_HOLD,
		EV_RELEASE,
		EV_SHORT
	} key_event_t;

	typedef enum logic [2:0] {
		MODE_OFF,
		MODE_ON,
		MODE_RISE,
		MODE_FALL,
		MODE_HIGH,
		MODE_LOW
	} light_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_QUAL,
		ST_DIV,
		ST_TICK
	} state_t;

	typedef struct packed {
		logic [1:0] channel;
		logic       pin_level;
	} item_t;

	typedef struct packed {
		logic [1:0]  channel_out;
		key_event_t  key_event;
		light_mode_t light_mode;
		logic        light_on;
		logic [15:0] brightness;
		logic [7:0]  duty;
	} result_t;

	typedef struct packed {
		light_mode_t mode;
		logic [15:0] level;
		logic [1:0]  flags;
		logic [15:0] tick;
		logic [15:0] high;
	} entry_t;

endpackage

### sv/bdc_ram.sv
module bdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/button_dimmer_channel_top.sv
// Push-button dimmer, one light per channel, state kept in a small RAM.
// item channel: one tick for one channel (channel, sampled pin_level).
// result channel: one item per tick: event, mode, on flag, 16-bit level, duty.
// cfg channel: register index and data, always ready; write only while idle.
// Each tick is a read-modify-write of the channel's RAM entry: read, qualify
// (counters and percent check), a 2-bit-per-cycle divider for the slow step,
// then the ramp and write-back. An item is taken only in IDLE, so the next
// item waits until the previous one has passed READ, QUAL, DIV and TICK.
// The result is loaded into the output register when TICK finds it free.
// The output register lets the next item be accepted while a result waits;
// a stalled receiver holds the block in the write-back step until the
// register frees up, so nothing is dropped.
// Reset clears the configuration to defaults and the per-entry valid bits;
// an entry never written reads as light off, level zero, counters zero.
// Ticks for a channel at or above NUM_CHANNELS change nothing and return a
// zero result carrying the channel number.
module button_dimmer_channel_top #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  bdc_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output bdc_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bdc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int EW = $bits(bdc_pkg::entry_t);

	// configuration
	logic [15:0] target_level_q;
	logic [7:0]  rise_step_q;
	logic [7:0]  fall_step_q;
	logic [7:0]  slow_div_q;
	logic [15:0] bounce_ticks_q;
	logic [15:0] hold_ticks_q;
	logic [6:0]  min_pct_q;

	// control
	bdc_pkg::state_t             state_q, state_d;
	logic [bdc_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [NUM_CHANNELS-1:0]     valid_q;
	logic                        res_valid_q;

	logic item_fire;
	logic out_free;
	logic ram_re, ram_we, res_load;
	logic chan_oor;

	// item context
	logic [1:0] chan_q;
	logic       pin_q;
	logic       oor_q;
	logic       vld_q;

	// RAM
	logic [AW-1:0] ram_raddr, ram_waddr;
	logic [EW-1:0] ram_rdata, ram_wdata;

	// read stage
	bdc_pkg::entry_t rd;
	logic [15:0] tick_inc, high_inc;
	logic [22:0] prod_high, prod_tick;
	bdc_pkg::entry_t ent_q;
	logic [15:0] tick_inc_q, high_inc_q;
	logic [22:0] prod_high_q, prod_tick_q;

	// qualify stage
	bdc_pkg::key_event_t  ev;
	bdc_pkg::light_mode_t mode_ev;
	logic [1:0]  flags_n;
	logic [15:0] tick_n, high_n;
	logic        hi;
	logic [7:0]  step_sel;
	bdc_pkg::key_event_t  ev_q;
	bdc_pkg::light_mode_t mode_ev_q;
	logic [1:0]  flags_n_q;
	logic [15:0] tick_n_q, high_n_q;

	// divider
	logic [7:0] div_rem_q, div_quo_q, divisor_q;
	logic [7:0] div_rem_d, div_quo_d;

	// tick stage
	logic [7:0]  dn_step, up_step;
	logic [15:0] dn_floor, up_top;
	logic        dn_snap, up_snap;
	logic [15:0] dn_val, up_val;
	logic [15:0] level_fin;
	bdc_pkg::light_mode_t mode_fin;
	bdc_pkg::entry_t wr_ent;
	bdc_pkg::result_t res_d, res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_level_q <= bdc_pkg::RST_TARGET_LEVEL;
			rise_step_q    <= bdc_pkg::RST_RISE_STEP;
			fall_step_q    <= bdc_pkg::RST_FALL_STEP;
			slow_div_q     <= bdc_pkg::RST_SLOW_DIVISOR;
			bounce_ticks_q <= bdc_pkg::RST_BOUNCE_TICKS;
			hold_ticks_q   <= bdc_pkg::RST_HOLD_TICKS;
			min_pct_q      <= bdc_pkg::RST_MIN_HIGH_PERCENT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bdc_pkg::REG_TARGET_LEVEL:     target_level_q <= cfg_data;
				bdc_pkg::REG_RISE_STEP:        rise_step_q    <= cfg_data[7:0];
				bdc_pkg::REG_FALL_STEP:        fall_step_q    <= cfg_data[7:0];
				bdc_pkg::REG_SLOW_DIVISOR:     slow_div_q     <= cfg_data[7:0];
				bdc_pkg::REG_BOUNCE_TICKS:     bounce_ticks_q <= cfg_data;
				bdc_pkg::REG_HOLD_TICKS:       hold_ticks_q   <= cfg_data;
				bdc_pkg::REG_MIN_HIGH_PERCENT: min_pct_q      <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign item_fire = item_valid && item_ready;
	assign out_free  = !res_valid_q || result_ready;
	assign chan_oor  = (32'(item.channel) >= NUM_CHANNELS);
	assign ram_raddr = AW'(item.channel);
	assign ram_waddr = AW'(chan_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bdc_pkg::ST_IDLE: begin
				if (item_fire) begin
					state_d = bdc_pkg::ST_READ;
				end
			end
			bdc_pkg::ST_READ: state_d = bdc_pkg::ST_QUAL;
			bdc_pkg::ST_QUAL: state_d = bdc_pkg::ST_DIV;
			bdc_pkg::ST_DIV: begin
				if (div_cnt_q == bdc_pkg::DIV_CNT_W'(bdc_pkg::DIV_CYCLES - 1)) begin
					state_d = bdc_pkg::ST_TICK;
				end
			end
			bdc_pkg::ST_TICK: begin
				if (out_free) begin
					state_d = bdc_pkg::ST_IDLE;
				end
			end
			default: state_d = bdc_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		item_ready = 1'b0;
		res_load   = 1'b0;
		case (state_q)
			bdc_pkg::ST_IDLE: item_ready = 1'b1;
			bdc_pkg::ST_TICK: res_load   = out_free;
			default: ;
		endcase
		ram_re = item_fire;
		ram_we = res_load && !oor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdc_pkg::ST_IDLE;
			div_cnt_q   <= '0;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bdc_pkg::ST_QUAL) begin
				div_cnt_q <= '0;
			end else if (state_q == bdc_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	bdc_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_CHANNELS)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read stage: increments and the products for the high-percent check
	always_comb begin
		rd        = vld_q ? bdc_pkg::entry_t'(ram_rdata) : '0;
		tick_inc  = (rd.tick != bdc_pkg::COUNT_MAX) ? rd.tick + 16'd1 : rd.tick;
		high_inc  = ((|(rd.flags & bdc_pkg::FLAGS_HIGH)) && pin_q &&
			(rd.high != bdc_pkg::COUNT_MAX)) ? rd.high + 16'd1 : rd.high;
		prod_high = 23'(high_inc) * 23'(bdc_pkg::PERCENT_SCALE);
		prod_tick = 23'(min_pct_q) * 23'(tick_inc);
	end

	// qualify: floor(h*100/t) < pct is the same as h*100 < pct*t
	always_comb begin
		hi      = |(ent_q.flags & bdc_pkg::FLAGS_HIGH);
		ev      = bdc_pkg::EV_NONE;
		flags_n = ent_q.flags;
		tick_n  = tick_inc_q;
		high_n  = high_inc_q;
		if (ent_q.tick == 16'd0) begin
			tick_n = ent_q.tick;
			high_n = ent_q.high;
			if (hi != pin_q) begin
				flags_n = pin_q ? bdc_pkg::FLAGS_HIGH : 2'b00;
				tick_n  = 16'd1;
				if (pin_q) begin
					high_n = 16'd1;
				end
			end
		end else if (tick_inc_q < bounce_ticks_q) begin
			ev = bdc_pkg::EV_NONE;
		end else if (tick_inc_q == bounce_ticks_q && hi && prod_high_q < prod_tick_q) begin
			tick_n = 16'd1;
			high_n = 16'd1;
		end else if (!hi) begin
			ev     = (|(ent_q.flags & bdc_pkg::FLAGS_ONCE)) ? bdc_pkg::EV_NONE
				: bdc_pkg::EV_RELEASE;
			tick_n = 16'd0;
			high_n = 16'd0;
		end else if (!pin_q) begin
			ev      = bdc_pkg::EV_SHORT;
			flags_n = bdc_pkg::FLAGS_ONCE;
			tick_n  = 16'd1;
			high_n  = 16'd0;
		end else if (tick_inc_q >= hold_ticks_q) begin
			ev     = bdc_pkg::EV_HOLD;
			tick_n = 16'd0;
			high_n = 16'd0;
		end

		mode_ev = ent_q.mode;
		case (ev)
			bdc_pkg::EV_SHORT: begin
				mode_ev = (ent_q.mode == bdc_pkg::MODE_OFF) ? bdc_pkg::MODE_ON
					: bdc_pkg::MODE_OFF;
			end
			bdc_pkg::EV_HOLD: begin
				if (ent_q.mode == bdc_pkg::MODE_OFF || ent_q.mode == bdc_pkg::MODE_LOW) begin
					mode_ev = bdc_pkg::MODE_RISE;
				end else if (ent_q.mode == bdc_pkg::MODE_ON ||
					ent_q.mode == bdc_pkg::MODE_HIGH) begin
					mode_ev = bdc_pkg::MODE_FALL;
				end
			end
			bdc_pkg::EV_RELEASE: begin
				if (ent_q.mode == bdc_pkg::MODE_RISE) begin
					mode_ev = bdc_pkg::MODE_HIGH;
				end else if (ent_q.mode == bdc_pkg::MODE_FALL) begin
					mode_ev = bdc_pkg::MODE_LOW;
				end
			end
			default: ;
		endcase

		step_sel = (mode_ev == bdc_pkg::MODE_RISE) ? rise_step_q : fall_step_q;
	end

	// restoring divider, two quotient bits per cycle
	always_comb begin
		logic [8:0] rem_sh;
		div_rem_d = div_rem_q;
		div_quo_d = div_quo_q;
		for (int i = 0; i < bdc_pkg::DIV_BITS_PER_CYCLE; i++) begin
			rem_sh    = {div_rem_d, div_quo_d[7]};
			div_quo_d = {div_quo_d[6:0], 1'b0};
			if (rem_sh >= {1'b0, divisor_q}) begin
				rem_sh       = rem_sh - {1'b0, divisor_q};
				div_quo_d[0] = 1'b1;
			end
			div_rem_d = rem_sh[7:0];
		end
	end

	// tick: ramp the level toward its floor or ceiling
	always_comb begin
		dn_step  = fall_step_q;
		dn_floor = 16'd0;
		up_step  = rise_step_q;
		up_top   = bdc_pkg::LEVEL_MAX;
		case (mode_ev_q)
			bdc_pkg::MODE_ON: begin
				dn_step  = rise_step_q;
				dn_floor = target_level_q;
				up_top   = target_level_q;
			end
			bdc_pkg::MODE_RISE: up_step = div_quo_q;
			bdc_pkg::MODE_FALL: dn_step = div_quo_q;
			default: ;
		endcase

		dn_snap = (dn_floor >= 16'(dn_step)) ||
			((17'(dn_floor) + 17'(dn_step)) >= 17'(ent_q.level));
		dn_val  = dn_snap ? dn_floor : ent_q.level - 16'(dn_step);
		up_snap = (up_top <= 16'(up_step)) || ((up_top - 16'(up_step)) <= ent_q.level);
		up_val  = up_snap ? up_top : ent_q.level + 16'(up_step);

		level_fin = ent_q.level;
		mode_fin  = mode_ev_q;
		case (mode_ev_q)
			bdc_pkg::MODE_OFF: level_fin = dn_val;
			bdc_pkg::MODE_ON: begin
				if (ent_q.level > target_level_q) begin
					level_fin = dn_val;
				end else if (ent_q.level < target_level_q) begin
					level_fin = up_val;
				end
			end
			bdc_pkg::MODE_RISE: begin
				level_fin = up_val;
				if (up_snap) begin
					mode_fin = bdc_pkg::MODE_HIGH;
				end
			end
			bdc_pkg::MODE_FALL: begin
				level_fin = dn_val;
				if (dn_snap) begin
					mode_fin = bdc_pkg::MODE_OFF;
				end
			end
			default: ;
		endcase

		wr_ent.mode  = mode_fin;
		wr_ent.level = level_fin;
		wr_ent.flags = flags_n_q;
		wr_ent.tick  = tick_n_q;
		wr_ent.high  = high_n_q;

		res_d = '0;
		res_d.channel_out = chan_q;
		if (!oor_q) begin
			res_d.key_event  = ev_q;
			res_d.light_mode = mode_fin;
			res_d.light_on   = (mode_fin != bdc_pkg::MODE_OFF);
			res_d.brightness = level_fin;
			res_d.duty       = level_fin[15:8];
		end
	end

	assign ram_wdata = wr_ent;

	always_ff @(posedge clk) begin
		if (item_fire) begin
			chan_q <= item.channel;
			pin_q  <= item.pin_level;
			oor_q  <= chan_oor;
			vld_q  <= !chan_oor && valid_q[ram_raddr];
		end
		if (state_q == bdc_pkg::ST_READ) begin
			ent_q       <= rd;
			tick_inc_q  <= tick_inc;
			high_inc_q  <= high_inc;
			prod_high_q <= prod_high;
			prod_tick_q <= prod_tick;
		end
		if (state_q == bdc_pkg::ST_QUAL) begin
			ev_q      <= ev;
			mode_ev_q <= mode_ev;
			flags_n_q <= flags_n;
			tick_n_q  <= tick_n;
			high_n_q  <= high_n;
			div_rem_q <= '0;
			div_quo_q <= step_sel;
			divisor_q <= (slow_div_q == 8'd0) ? 8'd1 : slow_div_q;
		end
		if (state_q == bdc_pkg::ST_DIV) begin
			div_rem_q <= div_rem_d;
			div_quo_q <= div_quo_d;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

### sv/bdc_checker.sv
module bdc_checker #(
	parameter int NUM_CHANNELS = 3
) (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             result_valid,
	input logic             result_ready,
	input bdc_pkg::result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before it was taken");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while the previous one is in flight");

	a_unused_channel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (32'(result.channel_out) >= NUM_CHANNELS) |->
		result.key_event == bdc_pkg::EV_NONE && result.light_mode == bdc_pkg::MODE_OFF &&
		!result.light_on && result.brightness == 16'd0 && result.duty == 8'd0)
		else $error("result for an unused channel is not zero");

endmodule

bind button_dimmer_channel_top bdc_checker #(
	.NUM_CHANNELS(NUM_CHANNELS)
) u_bdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
